>>> rtl/dfts_pkg.sv
// Shared types, constants and the character classifier of the decimal text scanner.
package dfts_pkg;

   localparam int CharWidth    = 8;
   localparam int MantWidth    = 57;
   localparam int ExpWidth     = 58;
   localparam int RspDataWidth = 120;

   localparam logic [MantWidth-1:0] AccLimit = 57'd9000000000000000;

   localparam logic [CharWidth-1:0] CH_PLUS   = 8'h2B;
   localparam logic [CharWidth-1:0] CH_MINUS  = 8'h2D;
   localparam logic [CharWidth-1:0] CH_POINT  = 8'h2E;
   localparam logic [CharWidth-1:0] CH_ZERO   = 8'h30;
   localparam logic [CharWidth-1:0] CH_NINE   = 8'h39;
   localparam logic [CharWidth-1:0] CH_EXP_UP = 8'h45;
   localparam logic [CharWidth-1:0] CH_EXP_LO = 8'h65;

   typedef enum logic [2:0] {
      CC_PLUS,
      CC_MINUS,
      CC_POINT,
      CC_DIGIT,
      CC_EXP,
      CC_OTHER
   } char_class_type;

   typedef struct packed {
      logic dot;
      logic ovf;
      logic bad;
   } err_type;

   typedef struct packed {
      logic                 sign_seen;
      logic                 minus_seen;
      logic                 in_exp;
      logic                 point_seen;
      logic [MantWidth-1:0] acc;
      logic [MantWidth-1:0] saved_mant;
      logic                 saved_neg;
      err_type              err;
   } scan_state_type;

   typedef struct packed {
      logic                 negative;
      logic [MantWidth-1:0] mantissa;
      logic                 exp_minus;
      logic [MantWidth-1:0] exp_mag;
      err_type              err;
   } raw_result_type;

   function automatic char_class_type classify(input logic [CharWidth-1:0] ch);
      char_class_type cc;
      unique case (ch) inside
         CH_PLUS:              cc = CC_PLUS;
         CH_MINUS:             cc = CC_MINUS;
         CH_POINT:             cc = CC_POINT;
         [CH_ZERO:CH_NINE]:    cc = CC_DIGIT;
         CH_EXP_UP, CH_EXP_LO: cc = CC_EXP;
         default:              cc = CC_OTHER;
      endcase
      return cc;
   endfunction

endpackage

>>> rtl/dfts_input_reg.sv
// Input register stage: holds one character beat until the scan core takes it.
module dfts_input_reg (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [dfts_pkg::CharWidth-1:0] req_tdata,
   input  logic                          req_tlast,
   input  logic                          core_take,
   output logic                          beat_valid,
   output logic [dfts_pkg::CharWidth-1:0] beat_char,
   output logic                          beat_last
);
   import dfts_pkg::*;

   logic                 valid_ff, valid_in;
   logic [CharWidth-1:0] char_ff;
   logic                 last_ff;
   logic                 load;

   assign req_tready = !valid_ff || core_take;
   assign load       = req_tvalid && req_tready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (core_take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         char_ff <= req_tdata;
         last_ff <= req_tlast;
      end
   end

   assign beat_valid = valid_ff;
   assign beat_char  = char_ff;
   assign beat_last  = last_ff;

endmodule

>>> rtl/dfts_scan_core.sv
// Scan state and one-character update; captures the raw result on the last beat.
module dfts_scan_core #(
   parameter int COUNT_BITS = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           beat_valid,
   input  logic [dfts_pkg::CharWidth-1:0] beat_char,
   input  logic                           beat_last,
   output logic                           core_take,
   input  logic                           raw_take,
   output logic                           raw_valid,
   output dfts_pkg::raw_result_type       raw,
   output logic [COUNT_BITS-1:0]          raw_frac
);
   import dfts_pkg::*;

   scan_state_type        st_ff, st_in, st_next;
   logic [COUNT_BITS-1:0] frac_ff, frac_in, frac_next;
   logic                  raw_valid_ff, raw_valid_in;
   raw_result_type        raw_ff;
   logic [COUNT_BITS-1:0] raw_frac_ff;
   logic [MantWidth-1:0]  acc_shifted;
   logic                  acc_over;
   logic                  new_over;
   char_class_type        cc;

   // a last beat waits only when the raw slot is full and not draining
   assign core_take = beat_valid && (!beat_last || !raw_valid_ff || raw_take);

   // acc*10 + digit as a shift-add
   assign acc_shifted = {st_ff.acc[MantWidth-4:0], 3'b000} + {st_ff.acc[MantWidth-2:0], 1'b0}
                        + {{(MantWidth-4){1'b0}}, beat_char[3:0]};
   assign acc_over    = st_ff.acc > AccLimit;
   assign new_over    = acc_shifted > AccLimit;
   assign cc          = classify(beat_char);

   always_comb begin
      st_next   = st_ff;
      frac_next = frac_ff;
      unique case (cc)
         CC_PLUS: begin
            if (!st_ff.sign_seen) begin
               st_next.sign_seen = 1'b1;
            end else begin
               st_next.err.bad = 1'b1;
            end
         end
         CC_MINUS: begin
            if (!st_ff.sign_seen) begin
               st_next.sign_seen  = 1'b1;
               st_next.minus_seen = 1'b1;
            end else begin
               st_next.err.bad = 1'b1;
            end
         end
         CC_POINT: begin
            if (st_ff.in_exp || st_ff.point_seen) begin
               st_next.err.dot = 1'b1;
            end else begin
               st_next.point_seen = 1'b1;
            end
         end
         CC_DIGIT: begin
            if (acc_over) begin
               st_next.err.ovf = 1'b1;
            end else begin
               st_next.acc = acc_shifted;
               if (new_over) begin
                  st_next.err.ovf = 1'b1;
               end else if (st_ff.point_seen && !st_ff.in_exp && (frac_ff != '1)) begin
                  frac_next = frac_ff + 1'b1;
               end
            end
         end
         CC_EXP: begin
            if (!st_ff.in_exp) begin
               st_next.in_exp     = 1'b1;
               st_next.saved_mant = st_ff.acc;
               st_next.saved_neg  = st_ff.minus_seen;
               st_next.minus_seen = 1'b0;
               st_next.acc        = '0;
               st_next.sign_seen  = 1'b0;
               st_next.point_seen = 1'b0;
            end else begin
               st_next.err.bad = 1'b1;
            end
         end
         default: begin
            st_next.err.bad = 1'b1;
         end
      endcase
   end

   always_comb begin
      st_in   = st_ff;
      frac_in = frac_ff;
      if (core_take) begin
         // a finished text leaves the scanner clean for the next one
         st_in   = beat_last ? '0 : st_next;
         frac_in = beat_last ? '0 : frac_next;
      end
      raw_valid_in = raw_valid_ff;
      if (core_take && beat_last) begin
         raw_valid_in = 1'b1;
      end else if (raw_take) begin
         raw_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= '0;
         frac_ff      <= '0;
         raw_valid_ff <= 1'b0;
      end else begin
         st_ff        <= st_in;
         frac_ff      <= frac_in;
         raw_valid_ff <= raw_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (core_take && beat_last) begin
         raw_ff.negative  <= st_next.in_exp ? st_next.saved_neg : st_next.minus_seen;
         raw_ff.mantissa  <= st_next.in_exp ? st_next.saved_mant : st_next.acc;
         raw_ff.exp_minus <= st_next.in_exp && st_next.minus_seen;
         raw_ff.exp_mag   <= st_next.in_exp ? st_next.acc : '0;
         raw_ff.err       <= st_next.err;
         raw_frac_ff      <= frac_next;
      end
   end

   assign raw_valid = raw_valid_ff;
   assign raw       = raw_ff;
   assign raw_frac  = raw_frac_ff;

endmodule

>>> rtl/dfts_result_fmt.sv
// Result stage: signed exponent minus fraction count, packed into the output register.
module dfts_result_fmt #(
   parameter int COUNT_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              raw_valid,
   input  dfts_pkg::raw_result_type          raw,
   input  logic [COUNT_BITS-1:0]             raw_frac,
   output logic                              raw_take,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [dfts_pkg::RspDataWidth-1:0] rsp_tdata
);
   import dfts_pkg::*;

   logic                    valid_ff, valid_in;
   logic [RspDataWidth-1:0] data_ff;
   logic [ExpWidth-1:0]     exp_signed;
   logic [ExpWidth-1:0]     exp_net;

   assign raw_take   = raw_valid && (!valid_ff || rsp_tready);
   assign exp_signed = raw.exp_minus ? (~{1'b0, raw.exp_mag} + 1'b1) : {1'b0, raw.exp_mag};
   assign exp_net    = exp_signed - {{(ExpWidth-COUNT_BITS){1'b0}}, raw_frac};

   always_comb begin
      valid_in = valid_ff;
      if (raw_take) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (raw_take) begin
         data_ff <= {1'b0, raw.err.bad, raw.err.ovf, raw.err.dot,
                     exp_net, raw.mantissa, raw.negative};
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;

endmodule

>>> rtl/decimal_float_text_scanner_top.sv
// Top level of the decimal number text scanner.
//
//  channel | dir | handshake          | content
//  req     | in  | tvalid/tready      | tdata: character; tlast: last character of the text
//  rsp     | out | tvalid/tready      | tdata: sign, mantissa, net exponent, error flags
//
// One character beat per cycle sustained while no last beat waits; the shift-add of the
// scan core sets that. A result leaves after the last beat of its text is accepted and
// has passed the input register, the scan core and the exponent subtract.
// Reset (synchronous) empties every stage and clears the scan state.
// While rsp stalls, non-last characters keep flowing; a last beat waits only
// when two results are already held downstream.
module decimal_float_text_scanner_top #(
   parameter int COUNT_BITS = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [dfts_pkg::CharWidth-1:0]    req_tdata,   // [7:0] character
   input  logic                              req_tlast,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [0] negative, [57:1] mantissa, [115:58] decimal_exponent, [116] dot_error,
   // [117] overflow_error, [118] bad_char_error, [119] zero
   output logic [dfts_pkg::RspDataWidth-1:0] rsp_tdata
);
   import dfts_pkg::*;

   logic                  core_take;
   logic                  beat_valid;
   logic [CharWidth-1:0]  beat_char;
   logic                  beat_last;
   logic                  raw_take;
   logic                  raw_valid;
   raw_result_type        raw;
   logic [COUNT_BITS-1:0] raw_frac;

   dfts_input_reg u_input_reg (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .core_take  (core_take),
      .beat_valid (beat_valid),
      .beat_char  (beat_char),
      .beat_last  (beat_last)
   );

   dfts_scan_core #(
      .COUNT_BITS (COUNT_BITS)
   ) u_scan_core (
      .clock      (clock),
      .reset      (reset),
      .beat_valid (beat_valid),
      .beat_char  (beat_char),
      .beat_last  (beat_last),
      .core_take  (core_take),
      .raw_take   (raw_take),
      .raw_valid  (raw_valid),
      .raw        (raw),
      .raw_frac   (raw_frac)
   );

   dfts_result_fmt #(
      .COUNT_BITS (COUNT_BITS)
   ) u_result_fmt (
      .clock      (clock),
      .reset      (reset),
      .raw_valid  (raw_valid),
      .raw        (raw),
      .raw_frac   (raw_frac),
      .raw_take   (raw_take),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

>>> rtl/dfts_checker.sv
// Port-level checks of the scanner top level, bound to it.
module dfts_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tvalid,
   input logic                              req_tready,
   input logic                              req_tlast,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [dfts_pkg::RspDataWidth-1:0] rsp_tdata
);
   import dfts_pkg::*;

   // texts whose last beat went in and whose result has not left yet
   logic [1:0] open_ff, open_in;
   logic       last_in_beat;
   logic       rsp_beat;

   assign last_in_beat = req_tvalid && req_tready && req_tlast;
   assign rsp_beat     = rsp_tvalid && rsp_tready;

   always_comb begin
      open_in = open_ff;
      if (last_in_beat && !rsp_beat) begin
         open_in = open_ff + 1'b1;
      end else if (rsp_beat && !last_in_beat) begin
         open_in = open_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff <= '0;
      end else begin
         open_ff <= open_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp beat changed while stalled");

   a_reset_empty: assert property (@(posedge clock) $past(reset) |-> !rsp_tvalid)
      else $error("rsp valid right after reset");

   a_no_bubble: assert property (@(posedge clock) disable iff (reset)
      (!rsp_tvalid || rsp_tready) |-> req_tready)
      else $error("input stalled while result side is free");

   a_has_text: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> open_ff != 2'd0)
      else $error("result without a finished text");

   a_mant_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[57:1] <= 57'd90000000000000009) && !rsp_tdata[119])
      else $error("mantissa out of range or pad bit set");

endmodule

bind decimal_float_text_scanner_top dfts_checker u_dfts_checker (.*);
